>>> sv/gtuc_pkg.sv
// Shared widths, constants, types and the month-length table of the GPS time to UTC
// calendar converter. No dependencies; every other file of the block imports this package.
`default_nettype none

package gtuc_pkg;

	// Field widths of the ports.
	localparam int WeekW  = 16;
	localparam int TowW   = 20;
	localparam int OffW   = 8;
	localparam int YearW  = 12;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int SecW   = 6;

	// Internal widths.
	localparam int SumW  = 21;  // time of week plus one day minus offset
	localparam int Wk7W  = 19;  // week number times seven
	localparam int DcntW = 4;   // whole days in the shifted week time, 0 to 8
	localparam int SodW  = 17;  // second of day
	localparam int RemW  = 12;  // second of hour
	localparam int BW    = 22;  // shifted Julian day number
	localparam int NW    = 29;  // scaled day count fed to the century division
	localparam int QW    = 14;  // first estimate of the quotient
	localparam int CW    = 13;  // corrected quotient
	localparam int XW    = 10;  // day within the March-based year
	localparam int EW    = 5;   // month index of the Julian-date method

	// Time constants.
	localparam logic [TowW-1:0] TowMax      = TowW'(604800);
	localparam logic [SumW-1:0] SecsPerDay  = SumW'(86400);
	localparam int              DayMax      = 8;
	localparam logic [SodW-1:0] SecsPerHour = SodW'(3600);
	localparam logic [RemW-1:0] SecsPerMin  = RemW'(60);

	// Julian day number of the day before the epoch plus the method's offset of 1537.
	localparam logic [BW-1:0] BBase = BW'(2444244 + 1537);

	// Century step: floor((100*b - 12210) / 36525) by reciprocal and one correction.
	localparam logic [NW-1:0]   NScale    = NW'(100);
	localparam logic [NW-1:0]   NBias     = NW'(12210);
	localparam logic [NW:0]     CDiv      = (NW+1)'(36525);
	localparam int              RecipK    = 44;
	localparam longint unsigned RecipFull = (64'd1 << RecipK) / 64'd36525;
	localparam logic [NW-1:0]   RecipC    = NW'(RecipFull);

	// Days of whole four-year cycles: floor(1461 * c / 4).
	localparam logic [23:0] DaysPerCycle = 24'd1461;

	// Time of day by reciprocal multiplication, exact over the full range.
	localparam int              HourK       = 28;
	localparam longint unsigned HourMulFull = ((64'd1 << HourK) + 64'd3599) / 64'd3600;
	localparam logic [SodW-1:0] HourMul     = SodW'(HourMulFull);
	localparam int              MinK        = 20;
	localparam longint unsigned MinMulFull  = ((64'd1 << MinK) + 64'd59) / 64'd60;
	localparam logic [14:0]     MinMul      = 15'(MinMulFull);

	// Calendar constants.
	localparam int              MonthIdxMax = 16;
	localparam logic [EW-1:0]   EWrap       = EW'(14);
	localparam logic [CW-1:0]   YearBias    = CW'(4715);
	localparam logic [MonthW-1:0] MonthFeb  = MonthW'(2);

	// Pipeline control that travels with each item.
	typedef struct packed {
		logic valid;
		logic inv;
	} gtuc_ctl_t;

	// floor(30.6001 * e): days before month index e in the March-based year.
	function automatic logic [XW-1:0] month_days(input logic [EW-1:0] e);
		logic [XW-1:0] r;
		unique case (e)
			5'd0:    r = 10'd0;
			5'd1:    r = 10'd30;
			5'd2:    r = 10'd61;
			5'd3:    r = 10'd91;
			5'd4:    r = 10'd122;
			5'd5:    r = 10'd153;
			5'd6:    r = 10'd183;
			5'd7:    r = 10'd214;
			5'd8:    r = 10'd244;
			5'd9:    r = 10'd275;
			5'd10:   r = 10'd306;
			5'd11:   r = 10'd336;
			5'd12:   r = 10'd367;
			5'd13:   r = 10'd397;
			5'd14:   r = 10'd428;
			5'd15:   r = 10'd459;
			5'd16:   r = 10'd489;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/gtuc_in_if.sv
// Input channel of the converter: GPS week and time of week with valid/ready.
// Depends on gtuc_pkg for the field widths.
`default_nettype none

interface gtuc_in_if import gtuc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WeekW-1:0]    week_num;
	logic [TowW-1:0]     time_of_week;

	modport source (output valid, week_num, time_of_week, input ready);
	modport sink   (input valid, week_num, time_of_week, output ready);
endinterface

`default_nettype wire

>>> sv/gtuc_out_if.sv
// Result channel of the converter: UTC calendar date and time with valid/ready.
// Depends on gtuc_pkg for the field widths.
`default_nettype none

interface gtuc_out_if import gtuc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic [YearW-1:0]   year;
	logic [MonthW-1:0]  month;
	logic [DayW-1:0]    day;
	logic [HourW-1:0]   hour;
	logic [MinW-1:0]    minute;
	logic [SecW-1:0]    second;

	modport source (output valid, valid_res, year, month, day, hour, minute, second,
		input ready);
	modport sink   (input valid, valid_res, year, month, day, hour, minute, second,
		output ready);
endinterface

`default_nettype wire

>>> sv/gtuc_cfg_if.sv
// Configuration write channel of the converter: the leap-second offset with valid/ready.
// Depends on gtuc_pkg for the register width.
`default_nettype none

interface gtuc_cfg_if import gtuc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OffW-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> sv/gtuc_split.sv
// Stages 1 and 2: removes the leap-second offset and splits the time into a shifted
// Julian day number and the second of day. Depends on gtuc_pkg.
`default_nettype none

module gtuc_split import gtuc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [WeekW-1:0]  week_num,
	input  wire logic [TowW-1:0]   time_of_week,
	input  wire logic [OffW-1:0]   offset,
	output logic      [BW-1:0]     b_s2,
	output logic      [SodW-1:0]   sod_s2
);

	logic [SumW-1:0]  s_s1;
	logic [Wk7W-1:0]  wk7_s1;
	logic [DcntW-1:0] qd;

	// Stage 1: time counted from one day before the week start, and week in days.
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= SumW'(time_of_week) + SecsPerDay - SumW'(offset);
			wk7_s1 <= Wk7W'(week_num) * Wk7W'(7);
		end
	end

	// Whole days in the shifted time, by parallel threshold compares.
	always_comb begin
		qd = '0;
		for (int k = 1; k <= DayMax; k++) begin
			if (s_s1 >= SumW'(k) * SecsPerDay) begin
				qd = qd + 1'b1;
			end
		end
	end

	// Stage 2: day number with the method's offset and the second of day.
	always_ff @(posedge clk) begin
		if (en) begin
			b_s2   <= BBase + BW'(wk7_s1) + BW'(qd);
			sod_s2 <= SodW'(s_s1 - SumW'(qd) * SecsPerDay);
		end
	end

endmodule

`default_nettype wire

>>> sv/gtuc_tod.sv
// Stages 3 to 8 of the time of day: hour, minute and second from the second of day
// by reciprocal multiplication. Depends on gtuc_pkg.
`default_nettype none

module gtuc_tod import gtuc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [SodW-1:0]  sod_s2,
	output logic      [HourW-1:0] hour_s8,
	output logic      [MinW-1:0]  minute_s8,
	output logic      [SecW-1:0]  second_s8
);

	logic [2*SodW-1:0] hprod;
	logic [RemW+14:0]  mprod;
	logic [SodW-1:0]   sod_s3;
	logic [HourW-1:0]  hour_s3, hour_s4, hour_s5, hour_s6, hour_s7;
	logic [RemW-1:0]   rem_s4, rem_s5;
	logic [MinW-1:0]   minute_s5, minute_s6, minute_s7;
	logic [SecW-1:0]   second_s6, second_s7;

	assign hprod = (2*SodW)'(sod_s2) * (2*SodW)'(HourMul);
	assign mprod = (RemW+15)'(rem_s4) * (RemW+15)'(MinMul);

	// Stage 3: hour estimate, exact for every second of day.
	always_ff @(posedge clk) begin
		if (en) begin
			sod_s3  <= sod_s2;
			hour_s3 <= hprod[HourK +: HourW];
		end
	end

	// Stage 4: second of hour.
	always_ff @(posedge clk) begin
		if (en) begin
			hour_s4 <= hour_s3;
			rem_s4  <= RemW'(sod_s3 - SodW'(hour_s3) * SecsPerHour);
		end
	end

	// Stage 5: minute of hour.
	always_ff @(posedge clk) begin
		if (en) begin
			hour_s5   <= hour_s4;
			rem_s5    <= rem_s4;
			minute_s5 <= mprod[MinK +: MinW];
		end
	end

	// Stage 6: second of minute.
	always_ff @(posedge clk) begin
		if (en) begin
			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			second_s6 <= SecW'(rem_s5 - RemW'(minute_s5) * SecsPerMin);
		end
	end

	// Stages 7 and 8: delay to line up with the calendar date.
	always_ff @(posedge clk) begin
		if (en) begin
			hour_s7   <= hour_s6;
			minute_s7 <= minute_s6;
			second_s7 <= second_s6;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			second_s8 <= second_s7;
		end
	end

endmodule

`default_nettype wire

>>> sv/gtuc_date.sv
// Stages 3 to 8 of the calendar date: Julian day number to year, month and day.
// The century division uses a reciprocal multiply and one correction. Depends on gtuc_pkg.
`default_nettype none

module gtuc_date import gtuc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [BW-1:0]      b_s2,
	output logic      [YearW-1:0]   year_s8,
	output logic      [MonthW-1:0]  month_s8,
	output logic      [DayW-1:0]    day_s8
);

	logic [NW-1:0]   n_s3, n_s4;
	logic [BW-1:0]   b_s3, b_s4, b_s5;
	logic [QW-1:0]   q0_s4;
	logic [CW-1:0]   c_s5, c_s6, c_s7;
	logic [XW-1:0]   x_s6, x_s7;
	logic [EW-1:0]   e_s7;
	logic [2*NW-1:0] qprod;
	logic [NW:0]     qback;
	logic [NW:0]     rem;
	logic [23:0]     cyc_days;
	logic [BW-1:0]   d;
	logic [EW-1:0]   e;
	logic [MonthW-1:0] month;

	// Stage 3: scaled day count.
	always_ff @(posedge clk) begin
		if (en) begin
			b_s3 <= b_s2;
			n_s3 <= NW'(b_s2) * NScale - NBias;
		end
	end

	// Stage 4: quotient estimate, low by at most one.
	assign qprod = (2*NW)'(n_s3) * (2*NW)'(RecipC);

	always_ff @(posedge clk) begin
		if (en) begin
			b_s4  <= b_s3;
			n_s4  <= n_s3;
			q0_s4 <= qprod[RecipK +: QW];
		end
	end

	// Stage 5: correct the estimate from its remainder.
	assign qback = (NW+1)'(q0_s4) * CDiv;
	assign rem   = (NW+1)'(n_s4) - qback;

	always_ff @(posedge clk) begin
		if (en) begin
			b_s5 <= b_s4;
			c_s5 <= CW'(q0_s4) + CW'(rem >= CDiv);
		end
	end

	// Stage 6: days left after the whole four-year cycles.
	assign cyc_days = 24'(c_s5) * DaysPerCycle;
	assign d        = BW'(cyc_days >> 2);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6 <= c_s5;
			x_s6 <= XW'(b_s5 - d);
		end
	end

	// Stage 7: month index from parallel compares against the month table.
	always_comb begin
		e = '0;
		for (int k = 1; k <= MonthIdxMax; k++) begin
			if (x_s6 > month_days(EW'(k))) begin
				e = e + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7 <= c_s6;
			x_s7 <= x_s6;
			e_s7 <= e;
		end
	end

	// Stage 8: day, month and year.
	assign month = (e_s7 < EWrap) ? MonthW'(e_s7 - EW'(1)) : MonthW'(e_s7 - EW'(13));

	always_ff @(posedge clk) begin
		if (en) begin
			day_s8   <= DayW'(x_s7 - month_days(e_s7));
			month_s8 <= month;
			year_s8  <= YearW'(c_s7 - YearBias - CW'(month > MonthFeb));
		end
	end

endmodule

`default_nettype wire

>>> sv/gps_time_to_utc_calendar_unit.sv
// GPS week and time of week to UTC calendar date and time. An eight-stage pipeline takes
// one transaction per clock; the throughput of one per cycle holds as long as the result
// side takes one per cycle, and a stall freezes every stage at once. The depth is set by
// the century division (multiply, correct) and the time-of-day chain of two reciprocal
// multiplies. A time of week above 604800 returns valid_res low with all other fields
// zero. The leap-second offset resets to zero; the user must write it through cfg only
// while no transaction is in flight, and the block does not enforce this.
`default_nettype none

module gps_time_to_utc_calendar_unit import gtuc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	gtuc_cfg_if.sink       cfg,
	gtuc_in_if.sink        gps,
	gtuc_out_if.source     utc
);

	logic [OffW-1:0]   offset_q;
	logic              en;
	gtuc_ctl_t         ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic [BW-1:0]     b_s2;
	logic [SodW-1:0]   sod_s2;
	logic [YearW-1:0]  year_s8;
	logic [MonthW-1:0] month_s8;
	logic [DayW-1:0]   day_s8;
	logic [HourW-1:0]  hour_s8;
	logic [MinW-1:0]   minute_s8;
	logic [SecW-1:0]   second_s8;

	// Leap-second offset register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg.valid) begin
			offset_q <= cfg.data;
		end
	end

	// The whole pipeline moves when the output register is empty or being taken.
	assign en        = !ctl_s8.valid || utc.ready;
	assign gps.ready = en;

	// Control pipeline: valid and out-of-range flag travel with each transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (en) begin
			ctl_s1.valid <= gps.valid;
			ctl_s1.inv   <= gps.time_of_week > TowMax;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			ctl_s4       <= ctl_s3;
			ctl_s5       <= ctl_s4;
			ctl_s6       <= ctl_s5;
			ctl_s7       <= ctl_s6;
			ctl_s8       <= ctl_s7;
		end
	end

	gtuc_split u_split (
		.clk          (clk),
		.en           (en),
		.week_num     (gps.week_num),
		.time_of_week (gps.time_of_week),
		.offset       (offset_q),
		.b_s2         (b_s2),
		.sod_s2       (sod_s2)
	);

	gtuc_tod u_tod (
		.clk       (clk),
		.en        (en),
		.sod_s2    (sod_s2),
		.hour_s8   (hour_s8),
		.minute_s8 (minute_s8),
		.second_s8 (second_s8)
	);

	gtuc_date u_date (
		.clk      (clk),
		.en       (en),
		.b_s2     (b_s2),
		.year_s8  (year_s8),
		.month_s8 (month_s8),
		.day_s8   (day_s8)
	);

	// Result: an out-of-range time of week reports zero fields.
	assign utc.valid     = ctl_s8.valid;
	assign utc.valid_res = !ctl_s8.inv;
	assign utc.year      = ctl_s8.inv ? '0 : year_s8;
	assign utc.month     = ctl_s8.inv ? '0 : month_s8;
	assign utc.day       = ctl_s8.inv ? '0 : day_s8;
	assign utc.hour      = ctl_s8.inv ? '0 : hour_s8;
	assign utc.minute    = ctl_s8.inv ? '0 : minute_s8;
	assign utc.second    = ctl_s8.inv ? '0 : second_s8;

`ifndef NO_ASSERTIONS
	// An accepted transaction enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(gps.valid && gps.ready) |=> ctl_s1.valid)
		else $error("accepted transaction did not enter stage 1");

	// A rejected time of week gives only zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(utc.valid && !utc.valid_res) |-> (utc.year == '0 && utc.month == '0 &&
		utc.day == '0 && utc.hour == '0 && utc.minute == '0 && utc.second == '0))
		else $error("invalid result with nonzero fields");

	// A converted date lies on the calendar after the epoch year began.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(utc.valid && utc.valid_res) |-> (utc.month >= MonthW'(1) &&
		utc.month <= MonthW'(12) && utc.day >= DayW'(1) && utc.day <= DayW'(31) &&
		utc.year >= YearW'(1980)))
		else $error("calendar date out of range");

	// The time of day stays within a day.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(utc.valid && utc.valid_res) |-> (utc.hour <= HourW'(23) &&
		utc.minute <= MinW'(59) && utc.second <= SecW'(59)))
		else $error("time of day out of range");
`endif

endmodule

`default_nettype wire
